// ===== sv/rtpd_pkg.sv =====
package rtpd_pkg;

  localparam int unsigned LengthBitsDefault = 16;
  localparam int unsigned QueueDepthDefault = 4;

  typedef enum logic [1:0] {
    ModeSingle,
    ModeStap,
    ModeFu,
    ModeDrop
  } mode_e;

  // FU-A uses PhaseLenHi for the FU header and PhaseBody for the fragment
  typedef enum logic [1:0] {
    PhaseLenHi,
    PhaseLenLo,
    PhaseBody,
    PhaseTail
  } phase_e;

  typedef enum logic [2:0] {
    StatusOk          = 3'd0,
    StatusEmpty       = 3'd1,
    StatusInvalid     = 3'd2,
    StatusUnsupported = 3'd3,
    StatusOverrun     = 3'd4
  } status_e;

  localparam logic [4:0] TypeSingleMax = 5'd23;
  localparam logic [4:0] TypeStapA     = 5'd24;
  localparam logic [4:0] TypeFuA       = 5'd28;
  localparam logic [4:0] TypeBad0      = 5'd30;
  localparam logic [4:0] TypeBad1      = 5'd31;

  localparam logic [7:0] NriMask       = 8'he0;
  localparam logic [7:0] TypeMask      = 8'h1f;
  localparam logic [7:0] StartCodeZero = 8'h00;
  localparam logic [7:0] StartCodeOne  = 8'h01;

  localparam logic KindByte   = 1'b0;
  localparam logic KindStatus = 1'b1;

  // result slots of one command: four start code bytes, payload byte, status
  localparam logic [2:0] PosFirstSc = 3'd0;
  localparam logic [2:0] PosLastSc  = 3'd3;
  localparam logic [2:0] PosByte    = 3'd4;
  localparam logic [2:0] PosStatus  = 3'd5;

  typedef struct packed {
    logic       start_code;
    logic       has_byte;
    logic [7:0] data;
    logic       has_status;
    status_e    status;
  } cmd_t;

endpackage

// ===== sv/rtpd_ifs.sv =====
interface rtpd_pkt_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        first_of_packet;
  logic [15:0] packet_length;

  modport source (output valid, data_byte, first_of_packet, packet_length, input ready);
  modport sink (input valid, data_byte, first_of_packet, packet_length, output ready);
endinterface

interface rtpd_strm_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       result_kind;
  logic [2:0] packet_status;
  logic       last_of_run;

  modport source (output valid, out_byte, result_kind, packet_status, last_of_run,
                  input ready);
  modport sink (input valid, out_byte, result_kind, packet_status, last_of_run,
                output ready);
endinterface

// ===== sv/rtpd_front.sv =====
module rtpd_front import rtpd_pkg::*; #(
  parameter int unsigned LENGTH_BITS = LengthBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rtpd_pkt_if.sink    pkt_i,
  output cmd_t        cmd_o,
  output logic        cmd_valid_o,
  input  logic        cmd_ready_i
);

  mode_e                  mode_q, mode_d;
  phase_e                 phase_q, phase_d;
  status_e                status_q, status_d;
  logic [LENGTH_BITS-1:0] bytes_left_q, bytes_left_d;
  logic [LENGTH_BITS-1:0] unit_left_q, unit_left_d;
  logic [7:0]             len_hi_q, len_hi_d;
  logic [7:0]             fu_ind_q, fu_ind_d;

  logic                   acc;
  logic [7:0]             b;
  logic [4:0]             hdr_type;
  logic [LENGTH_BITS-1:0] len;
  logic [LENGTH_BITS-1:0] len_m1;
  logic [LENGTH_BITS-1:0] left_m1;
  logic [15:0]            unit_size;
  logic                   size_fits;

  assign pkt_i.ready = cmd_ready_i;
  assign acc         = pkt_i.valid && cmd_ready_i;
  assign b           = pkt_i.data_byte;
  assign hdr_type    = b[4:0];
  assign len         = pkt_i.packet_length[LENGTH_BITS-1:0];
  assign len_m1      = len - LENGTH_BITS'(1);
  assign left_m1     = bytes_left_q - LENGTH_BITS'(1);
  assign unit_size   = {len_hi_q, b};
  assign size_fits   = unit_size <= 16'(left_m1);

  // next state
  always_comb begin
    mode_d       = mode_q;
    phase_d      = phase_q;
    status_d     = status_q;
    bytes_left_d = bytes_left_q;
    unit_left_d  = unit_left_q;
    len_hi_d     = len_hi_q;
    fu_ind_d     = fu_ind_q;
    if (acc) begin
      if (pkt_i.first_of_packet) begin
        status_d = StatusOk;
        if (len == '0) begin
          bytes_left_d = '0;
          mode_d       = ModeSingle;
        end else begin
          bytes_left_d = len_m1;
          phase_d      = PhaseLenHi;
          unit_left_d  = '0;
          unique case (hdr_type) inside
            [5'd0:TypeSingleMax]: mode_d = ModeSingle;
            TypeStapA:            mode_d = ModeStap;
            TypeFuA: begin
              if (len < LENGTH_BITS'(3)) begin
                mode_d   = ModeDrop;
                status_d = StatusInvalid;
              end else begin
                mode_d   = ModeFu;
                fu_ind_d = b;
              end
            end
            TypeBad0, TypeBad1: begin
              mode_d   = ModeDrop;
              status_d = StatusInvalid;
            end
            default: begin
              mode_d   = ModeDrop;
              status_d = StatusUnsupported;
            end
          endcase
        end
      end else if (bytes_left_q != '0) begin
        bytes_left_d = left_m1;
        unique case (mode_q)
          ModeStap: begin
            unique case (phase_q)
              PhaseLenHi: begin
                if (bytes_left_q <= LENGTH_BITS'(2)) begin
                  phase_d = PhaseTail;
                end else begin
                  len_hi_d = b;
                  phase_d  = PhaseLenLo;
                end
              end
              PhaseLenLo: begin
                if (size_fits) begin
                  unit_left_d = unit_size[LENGTH_BITS-1:0];
                  phase_d     = (unit_size != '0) ? PhaseBody : PhaseLenHi;
                end else begin
                  status_d = StatusOverrun;
                  mode_d   = ModeDrop;
                end
              end
              PhaseBody: begin
                unit_left_d = unit_left_q - LENGTH_BITS'(1);
                if (unit_left_q == LENGTH_BITS'(1)) begin
                  phase_d = PhaseLenHi;
                end
              end
              PhaseTail: ;
            endcase
          end
          ModeFu: begin
            if (phase_q == PhaseLenHi) begin
              phase_d = PhaseBody;
            end
          end
          ModeSingle, ModeDrop: ;
        endcase
      end
    end
  end

  // command for the back end
  always_comb begin
    cmd_o = '0;
    if (acc) begin
      if (pkt_i.first_of_packet) begin
        if (len == '0) begin
          cmd_o.has_status = 1'b1;
          cmd_o.status     = StatusEmpty;
        end else begin
          if (hdr_type <= TypeSingleMax) begin
            cmd_o.start_code = 1'b1;
            cmd_o.has_byte   = 1'b1;
            cmd_o.data       = b;
          end
          cmd_o.has_status = (len_m1 == '0);
          cmd_o.status     = status_d;
        end
      end else if (bytes_left_q != '0) begin
        case (mode_q)
          ModeSingle: begin
            cmd_o.has_byte = 1'b1;
            cmd_o.data     = b;
          end
          ModeStap: begin
            if (phase_q == PhaseLenLo && size_fits) begin
              cmd_o.start_code = 1'b1;
            end else if (phase_q == PhaseBody) begin
              cmd_o.has_byte = 1'b1;
              cmd_o.data     = b;
            end
          end
          ModeFu: begin
            if (phase_q == PhaseLenHi) begin
              // rebuilt NAL header: NRI from the indicator, type from the FU header
              if (b[7]) begin
                cmd_o.start_code = 1'b1;
                cmd_o.has_byte   = 1'b1;
                cmd_o.data       = (fu_ind_q & NriMask) | (b & TypeMask);
              end
            end else begin
              cmd_o.has_byte = 1'b1;
              cmd_o.data     = b;
            end
          end
          default: ;
        endcase
        cmd_o.has_status = (left_m1 == '0);
        cmd_o.status     = status_d;
      end
    end
  end

  assign cmd_valid_o = acc && (cmd_o.start_code || cmd_o.has_byte || cmd_o.has_status);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= ModeSingle;
      phase_q      <= PhaseLenHi;
      status_q     <= StatusOk;
      bytes_left_q <= '0;
      unit_left_q  <= '0;
      len_hi_q     <= '0;
      fu_ind_q     <= '0;
    end else begin
      mode_q       <= mode_d;
      phase_q      <= phase_d;
      status_q     <= status_d;
      bytes_left_q <= bytes_left_d;
      unit_left_q  <= unit_left_d;
      len_hi_q     <= len_hi_d;
      fu_ind_q     <= fu_ind_d;
    end
  end

endmodule

// ===== sv/rtpd_queue.sv =====
module rtpd_queue import rtpd_pkg::*; #(
  parameter int unsigned DEPTH = QueueDepthDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t cmd_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  cmd_t            mem_q [DEPTH];
  logic [PtrW-1:0] wr_q, wr_d;
  logic [PtrW-1:0] rd_q, rd_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign cmd_o   = mem_q[rd_q];

  always_comb begin
    wr_d    = wr_q;
    rd_d    = rd_q;
    count_d = count_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH)) else $error("queue count beyond depth");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> count_q == $past(count_q) + CntW'(1))
    else $error("queue count did not grow on push");

endmodule

// ===== sv/rtpd_back.sv =====
module rtpd_back import rtpd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  input  logic        cmd_empty_i,
  output logic        cmd_pop_o,
  rtpd_strm_if.source strm_o
);

  cmd_t       cmd_q, cmd_d;
  logic       cur_valid_q, cur_valid_d;
  logic [2:0] pos_q, pos_d;
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       kind_q, kind_d;
  status_e    status_q, status_d;
  logic       last_q, last_d;

  logic       out_adv;
  logic       emit;
  logic       is_last;
  logic [2:0] next_pos;
  logic [2:0] first_pos;

  assign out_adv = !out_valid_q || strm_o.ready;
  assign emit    = cur_valid_q && out_adv;

  assign is_last = (pos_q == PosStatus)
                || (pos_q == PosByte && !cmd_q.has_status)
                || (pos_q == PosLastSc && !cmd_q.has_byte && !cmd_q.has_status);

  always_comb begin
    if (pos_q < PosLastSc) begin
      next_pos = pos_q + 3'd1;
    end else if (pos_q == PosLastSc && cmd_q.has_byte) begin
      next_pos = PosByte;
    end else begin
      next_pos = PosStatus;
    end
  end

  assign first_pos = cmd_i.start_code ? PosFirstSc :
                     cmd_i.has_byte   ? PosByte    : PosStatus;

  assign cmd_pop_o = !cmd_empty_i && (!cur_valid_q || (emit && is_last));

  always_comb begin
    cmd_d       = cmd_q;
    pos_d       = pos_q;
    cur_valid_d = cur_valid_q;
    if (emit) begin
      if (is_last) begin
        cur_valid_d = 1'b0;
      end else begin
        pos_d = next_pos;
      end
    end
    if (cmd_pop_o) begin
      cmd_d       = cmd_i;
      pos_d       = first_pos;
      cur_valid_d = 1'b1;
    end
  end

  always_comb begin
    out_byte_d = StartCodeZero;
    kind_d     = KindByte;
    status_d   = StatusOk;
    last_d     = is_last;
    if (pos_q == PosLastSc) begin
      out_byte_d = StartCodeOne;
    end else if (pos_q == PosByte) begin
      out_byte_d = cmd_q.data;
    end else if (pos_q == PosStatus) begin
      kind_d   = KindStatus;
      status_d = cmd_q.status;
    end
    out_valid_d = out_adv ? emit : out_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q <= out_byte_d;
      kind_q     <= kind_d;
      status_q   <= status_d;
      last_q     <= last_d;
    end
    if (cmd_pop_o) begin
      cmd_q <= cmd_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      pos_q       <= PosFirstSc;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign strm_o.valid         = out_valid_q;
  assign strm_o.out_byte      = out_byte_q;
  assign strm_o.result_kind   = kind_q;
  assign strm_o.packet_status = status_q;
  assign strm_o.last_of_run   = last_q;

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_valid_q |-> pos_q <= PosStatus) else $error("result slot out of range");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strm_o.valid && strm_o.result_kind == KindStatus) |-> strm_o.last_of_run)
    else $error("status result not last of its run");

endmodule

// ===== sv/rtp_h264_depacketizer_unit.sv =====
// RTP H.264 depacketizer (non-interleaved mode) emitting an Annex B byte stream.
// Payload bytes come in one per request on pkt_i, with first_of_packet and
// packet_length on the first byte of each packet; results go out on strm_o, one
// per request: stream bytes (result_kind 0) and one status per packet
// (result_kind 1) on that packet's last byte. The front end accepts one byte per
// cycle while the command queue has room and classifies it into a command (start
// code, byte, status); a QUEUE_DEPTH-entry command queue decouples it from the
// back end, which issues one result per cycle while strm_o is ready. A byte that
// opens a NAL unit yields up to six results, so the sustained input rate is one
// byte per cycle for pass-through data and is set by the one-result-per-cycle
// output port around start codes. Results pass the queue, a command register and
// the output register. Only the low LENGTH_BITS bits of packet_length are used.
module rtp_h264_depacketizer_unit import rtpd_pkg::*; #(
  parameter int unsigned LENGTH_BITS = LengthBitsDefault,
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rtpd_pkt_if.sink    pkt_i,
  rtpd_strm_if.source strm_o
);

  cmd_t front_cmd;
  logic front_valid;
  logic q_full;
  cmd_t q_cmd;
  logic q_empty;
  logic q_pop;

  rtpd_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pkt_i      (pkt_i),
    .cmd_o      (front_cmd),
    .cmd_valid_o(front_valid),
    .cmd_ready_i(!q_full)
  );

  rtpd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (front_valid),
    .cmd_i  (front_cmd),
    .full_o (q_full),
    .pop_i  (q_pop),
    .cmd_o  (q_cmd),
    .empty_o(q_empty)
  );

  rtpd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (q_cmd),
    .cmd_empty_i(q_empty),
    .cmd_pop_o  (q_pop),
    .strm_o     (strm_o)
  );

endmodule
